// ===== hdl/external_clock_period_tracker_macros.svh =====
// Assertion macros for the clock period tracker checker.
`ifndef EXTERNAL_CLOCK_PERIOD_TRACKER_MACROS_SVH
`define EXTERNAL_CLOCK_PERIOD_TRACKER_MACROS_SVH

// Generic clocked check, disabled while in reset
`define ECPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ecpt check failed");

// A stalled stream word keeps its valid and payload
`define ECPT_ASSERT_HOLD(lbl, vld, rdy, sig) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (vld && !rdy) |=> (vld && $stable(sig))) \
        else $error("ecpt stalled word changed");

`endif

// ===== hdl/ecpt_pkg.sv =====
package ecpt_pkg;

    // Default parameter values
    localparam int FRAC_BITS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 24;

    // Fixed field widths
    localparam int BLK_W      = 11;
    localparam int PER_REG_W  = 21;
    localparam int SIL_REG_W  = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int PERIOD_OUT_W = 29;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX      = 2'd3;

    // Register reset values
    localparam logic [PER_REG_W-1:0] FALLBACK_RST = 21'd24000;
    localparam logic [SIL_REG_W-1:0] SILENCE_RST  = 23'd96000;
    localparam logic [PER_REG_W-1:0] MIN_RST      = 21'd2400;
    localparam logic [PER_REG_W-1:0] MAX_RST      = 21'd960000;

    // Smoothing weight 0.3 in Q0.16 and rounding half
    localparam logic signed [16:0] ALPHA_Q16  = 17'sd19661;
    localparam int                 ROUND_HALF = 32768;

    typedef struct packed {
        logic [PER_REG_W-1:0] fallback_period;
        logic [SIL_REG_W-1:0] silence_floor;
        logic [PER_REG_W-1:0] min_period;
        logic [PER_REG_W-1:0] max_period;
    } t_cfg;

    // Fallback write event, reloads the period while unlocked
    typedef struct packed {
        logic                 load;
        logic [PER_REG_W-1:0] value;
    } t_fb_load;

    typedef struct packed {
        logic                    tick_out;
        logic                    locked_external;
        logic [PERIOD_OUT_W-1:0] period_q8;
    } t_result;

endpackage

// ===== hdl/ecpt_cfg_regs.sv =====
module ecpt_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [ecpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ecpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ecpt_pkg::t_cfg                  o_cfg,
    output ecpt_pkg::t_fb_load              o_fb
);
    import ecpt_pkg::*;

    t_cfg r_cfg;

    // Register file, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fallback_period <= FALLBACK_RST;
            r_cfg.silence_floor   <= SILENCE_RST;
            r_cfg.min_period      <= MIN_RST;
            r_cfg.max_period      <= MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FALLBACK: r_cfg.fallback_period <= i_cfg_data[PER_REG_W-1:0];
                REG_SILENCE:  r_cfg.silence_floor   <= i_cfg_data[SIL_REG_W-1:0];
                REG_MIN:      r_cfg.min_period      <= i_cfg_data[PER_REG_W-1:0];
                REG_MAX:      r_cfg.max_period      <= i_cfg_data[PER_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // Fallback write seen by the core in the same cycle
    assign o_fb.load  = i_cfg_valid && (i_cfg_index == REG_FALLBACK);
    assign o_fb.value = i_cfg_data[PER_REG_W-1:0];

endmodule

// ===== hdl/ecpt_core.sv =====
module ecpt_core #(
    parameter int FRAC_BITS   = ecpt_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = ecpt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ecpt_pkg::t_cfg             i_cfg,
    input  ecpt_pkg::t_fb_load         i_fb,
    input  logic                       i_advance,
    input  logic                       i_edge,
    input  logic [ecpt_pkg::BLK_W-1:0] i_blk,
    output ecpt_pkg::t_result          o_result
);
    import ecpt_pkg::*;

    // Period width: 21 integer bits plus the fraction
    localparam int PW = PER_REG_W + FRAC_BITS;
    // Counter sum width, wide enough for 5 x max_period
    localparam int SW = (COUNT_WIDTH + 1 > 24) ? COUNT_WIDTH + 1 : 24;
    // Fixed-point compare width for the silence test
    localparam int FW = ((COUNT_WIDTH > SIL_REG_W) ? COUNT_WIDTH : SIL_REG_W) + FRAC_BITS;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [PW-1:0]          r_period, n_period;
    logic                   r_seen, n_seen;
    logic                   r_meas, n_meas;
    logic                   r_ext, n_ext;

    logic                   in_range;
    logic [PW-1:0]          target;
    logic signed [PW:0]     diff;
    logic signed [PW+17:0]  prod;
    logic signed [PW+17:0]  rnd;
    logic [SW-1:0]          cap5;
    logic [SW-1:0]          cap;
    logic [SW-1:0]          count_max;
    logic [SW-1:0]          c_sum;
    logic [SW-1:0]          c_sat;
    logic                   silent;

    assign count_max = {{(SW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

    // Interval check and exponential smoothing: p + ((t - p) * alpha + half) >> 16
    assign in_range = (SW'(r_count) >= SW'(i_cfg.min_period))
                   && (SW'(r_count) <= SW'(i_cfg.max_period));
    assign target   = PW'(r_count) << FRAC_BITS;
    assign diff     = $signed({1'b0, target}) - $signed({1'b0, r_period});
    assign prod     = diff * ALPHA_Q16;
    assign rnd      = prod + $signed((PW+18)'(ROUND_HALF));

    // Saturating count since the last edge
    assign cap5  = (SW'(i_cfg.max_period) << 2) + SW'(i_cfg.max_period);
    assign cap   = (cap5 > count_max) ? count_max : cap5;
    assign c_sum = SW'(r_count) + SW'(i_blk);
    assign c_sat = (c_sum > cap) ? cap : c_sum;

    // Silence longer than both 4 x period and the floor
    assign silent = ((FW'(c_sat) << FRAC_BITS) > (FW'(r_period) << 2))
                 && (c_sat > SW'(i_cfg.silence_floor));

    // Next state for the word in the input register
    always_comb begin
        n_count  = r_count;
        n_period = r_period;
        n_seen   = r_seen;
        n_meas   = r_meas;
        n_ext    = r_ext;
        if (i_edge) begin
            if (r_seen && in_range) begin
                n_period = r_meas ? (r_period + rnd[PW+15:16]) : target;
                n_meas   = 1'b1;
                n_ext    = 1'b1;
            end
            n_seen  = 1'b1;
            n_count = '0;
        end else begin
            n_count = c_sat[COUNT_WIDTH-1:0];
            if (r_ext) begin
                if (silent) begin
                    n_ext    = 1'b0;
                    n_meas   = 1'b0;
                    n_seen   = 1'b0;
                    n_period = PW'(i_cfg.fallback_period) << FRAC_BITS;
                end
            end else if (c_sat > SW'(i_cfg.max_period)) begin
                n_seen = 1'b0;
            end
        end
    end

    // Tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_period <= PW'(FALLBACK_RST) << FRAC_BITS;
            r_seen   <= 1'b0;
            r_meas   <= 1'b0;
            r_ext    <= 1'b0;
        end else if (i_advance) begin
            r_count  <= n_count;
            r_period <= n_period;
            r_seen   <= n_seen;
            r_meas   <= n_meas;
            r_ext    <= n_ext;
        end else if (i_fb.load && !r_ext) begin
            r_period <= PW'(i_fb.value) << FRAC_BITS;
        end
    end

    assign o_result.tick_out        = i_edge;
    assign o_result.locked_external = n_ext;
    assign o_result.period_q8       = PERIOD_OUT_W'(n_period);

endmodule

// ===== hdl/external_clock_period_tracker.sv =====
// External clock period tracker. Each slave word is one audio block (tuser: the
// clock-edge flag, tdata: the block's sample count); each produces exactly one
// master word with the edge echo, the external-lock flag and the period in
// samples with FRAC_BITS fraction bits. A word can be accepted every clock cycle
// while the master side keeps taking results. The word waits in the input
// register, then the combinational update of the counter and period loads the
// result register once that is free or being taken, and the result is then on
// the master side. While a result is held by the master side, the input register
// takes one more word and then the slave side stalls.
// The configuration channel is always ready; write it only while no word is in
// flight.
module external_clock_period_tracker #(
    parameter int FRAC_BITS   = ecpt_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = ecpt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [15:0]                     i_s_tdata,   // [10:0] block_samples
    input  logic [0:0]                      i_s_tuser,   // [0] ext_edge
    // Master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,   // [28:0] period_q8
    output logic [1:0]                      o_m_tuser,   // [0] tick_out, [1] locked_external
    // Configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ecpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ecpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ecpt_pkg::*;

    logic             r_in_valid;
    logic             r_in_edge;
    logic [BLK_W-1:0] r_in_blk;
    logic             r_out_valid;
    t_result          r_out;
    logic             advance;
    t_cfg             cfg;
    t_fb_load         fb;
    t_result          result;

    assign o_cfg_ready = 1'b1;

    ecpt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_fb        (fb)
    );

    ecpt_core #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_fb      (fb),
        .i_advance (advance),
        .i_edge    (r_in_edge),
        .i_blk     (r_in_blk),
        .o_result  (result)
    );

    // Word moves to the result register when that is free or being taken
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_edge <= i_s_tuser[0];
            r_in_blk  <= i_s_tdata[BLK_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(32-PERIOD_OUT_W){1'b0}}, r_out.period_q8};
    assign o_m_tuser  = {r_out.locked_external, r_out.tick_out};

endmodule

// ===== hdl/ecpt_checker.sv =====
`include "external_clock_period_tracker_macros.svh"

module ecpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // Stalled result word holds
    `ECPT_ASSERT_HOLD(a_out_hold, o_m_tvalid, i_m_tready, {o_m_tuser, o_m_tdata})

    // With the result register empty the input side never stalls
    `ECPT_ASSERT(a_ready_when_empty, !o_m_tvalid |-> o_s_tready)

    // An accepted word is followed by a valid word on the master side
    `ECPT_ASSERT(a_latency, (i_s_tvalid && o_s_tready) |=> ##1 o_m_tvalid)

    // Padding above the period stays clear
    `ECPT_ASSERT(a_pad_zero, o_m_tvalid |-> (o_m_tdata[31:29] == 3'b000))

endmodule

bind external_clock_period_tracker ecpt_checker u_ecpt_checker (.*);

// ===== verif/external_clock_period_tracker_tb.sv =====
module external_clock_period_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecpt_pkg::*;

    localparam int          FRAC           = FRAC_BITS_DEF;
    localparam logic [63:0] COUNT_CEIL     = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;
    localparam logic [63:0] SMOOTH_NEW     = 64'd19661;
    localparam logic [63:0] SMOOTH_OLD     = 64'd65536 - SMOOTH_NEW;
    localparam int          QUIET_LIMIT    = 1000;
    localparam int          PRINT_LIMIT    = 40;

    typedef struct packed {
        logic        gate;
        logic [10:0] blk;
        logic        settle;   // hold back until every report has come
    } t_audio_block;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [15:0]           i_s_tdata   = '0;
    logic [0:0]            i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [31:0]           o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Tracker state as predicted
    logic [PER_REG_W-1:0] cfg_fallback;
    logic [SIL_REG_W-1:0] cfg_silence;
    logic [PER_REG_W-1:0] cfg_min;
    logic [PER_REG_W-1:0] cfg_max;
    logic [63:0]          trk_count;
    logic [63:0]          trk_period;
    logic                 trk_seen;
    logic                 trk_meas;
    logic                 trk_ext;

    t_audio_block audio_blocks_pending[$];
    t_result      period_reports_due[$];

    int unsigned err_count    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned s_gap        = 0;
    int unsigned s_calm       = 0;
    int unsigned m_stall      = 0;
    int unsigned m_calm       = 0;
    bit          s_taken      = 1'b0;
    bit          m_taken      = 1'b0;

    external_clock_period_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [10:0] block_samples
        .i_s_tuser   (i_s_tuser),   // [0] ext_edge
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [28:0] period_q8
        .o_m_tuser   (o_m_tuser),   // [0] tick_out, [1] locked_external
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_error(input string msg);
        if (err_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Advance the tracker by one audio block and return its report
    function automatic t_result track_block(input logic gate, input logic [10:0] blk);
        logic [63:0] cap;
        logic [63:0] cnt;
        logic [63:0] target;
        t_result     r;
        if (gate) begin
            if (trk_seen && trk_count >= cfg_min && trk_count <= cfg_max) begin
                target = trk_count << FRAC;
                if (!trk_meas)
                    trk_period = target;
                else
                    trk_period = (trk_period * SMOOTH_OLD + target * SMOOTH_NEW
                                  + 64'd32768) >> 16;
                trk_meas = 1'b1;
                trk_ext  = 1'b1;
            end
            trk_seen  = 1'b1;
            trk_count = '0;
        end else begin
            cap = 64'd5 * cfg_max;
            if (cap > COUNT_CEIL)
                cap = COUNT_CEIL;
            cnt = trk_count + blk;
            if (cnt > cap)
                cnt = cap;
            trk_count = cnt;
            if (trk_ext) begin
                // silence long enough: drop back to the default period
                if ((cnt << FRAC) > 64'd4 * trk_period && cnt > cfg_silence) begin
                    trk_ext    = 1'b0;
                    trk_meas   = 1'b0;
                    trk_seen   = 1'b0;
                    trk_period = {43'd0, cfg_fallback} << FRAC;
                end
            end else if (cnt > cfg_max) begin
                // lone edge too old to pair with the next one
                trk_seen = 1'b0;
            end
        end
        r.tick_out        = gate;
        r.locked_external = trk_ext;
        r.period_q8       = trk_period[PERIOD_OUT_W-1:0];
        return r;
    endfunction

    // Idle cycles before the next word; occasional stretches run flat out
    function automatic int unsigned draw_wait(ref int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic void push_block(input logic gate, input logic [10:0] blk,
                                       input logic settle);
        t_audio_block b;
        b.gate   = gate;
        b.blk    = blk;
        b.settle = settle;
        audio_blocks_pending.push_back(b);
    endfunction

    // A steady external clock: edges about span samples apart
    task automatic queue_clock(input int unsigned span, input int unsigned blk_hi,
                               input int unsigned n_edges);
        int unsigned acc;
        int unsigned b;
        if (blk_hi > 2047)
            blk_hi = 2047;
        repeat (n_edges) begin
            acc = 0;
            while (acc < span) begin
                b = $urandom_range(1, blk_hi);
                push_block(1'b0, 11'(b), 1'b0);
                acc += b;
            end
            push_block(1'b1, 11'($urandom_range(0, 2047)), 1'b0);
        end
    endtask

    // Mostly clean clock runs, with noise, silences and the odd settle point
    task automatic queue_traffic(input int unsigned n_words);
        int unsigned n_before;
        int unsigned p_lo;
        int unsigned p_hi;
        int unsigned span;
        int unsigned target;
        int unsigned b;
        int unsigned n;
        n_before = audio_blocks_pending.size();
        p_lo = cfg_min / 2 + 1;
        p_hi = cfg_max + cfg_max / 4 + 1;
        while (audio_blocks_pending.size() - n_before < n_words) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    span = $urandom_range(p_lo, p_hi);
                    queue_clock(span, span / 3 + 1, $urandom_range(1, 4));
                end
                6, 7: begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                        push_block($urandom_range(0, 2) == 0,
                                   11'($urandom_range(0, 2047)), 1'b0);
                end
                8: begin
                    target = $urandom_range(cfg_max, 5 * cfg_max + cfg_silence + 1);
                    b = $urandom_range(512, 2047);
                    n = target / b + 1;
                    if (n > 300)
                        n = 300;
                    repeat (n)
                        push_block(1'b0, 11'(b), 1'b0);
                end
                default: begin
                    push_block(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                               1'b1);
                end
            endcase
        end
    endtask

    // Register write; the caller lowers valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [22:0] value);
        logic [22:0] word;
        word = value;
        if (idx != REG_SILENCE)
            word[22:21] = 2'($urandom_range(0, 3));
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FALLBACK: begin
                cfg_fallback = word[20:0];
                if (!trk_ext)
                    trk_period = {43'd0, cfg_fallback} << FRAC;
            end
            REG_SILENCE: cfg_silence = word;
            REG_MIN:     cfg_min     = word[20:0];
            REG_MAX:     cfg_max     = word[20:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned fb, input int unsigned sil,
                             input int unsigned mn, input int unsigned mx);
        write_reg(REG_FALLBACK, 23'(fb));
        write_reg(REG_SILENCE, 23'(sil));
        write_reg(REG_MIN, 23'(mn));
        write_reg(REG_MAX, 23'(mx));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (audio_blocks_pending.size() > 0 || i_s_tvalid
               || period_reports_due.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sequencer: reset, then phases of settings and traffic
    initial begin
        cfg_fallback = FALLBACK_RST;
        cfg_silence  = SILENCE_RST;
        cfg_min      = MIN_RST;
        cfg_max      = MAX_RST;
        trk_count    = '0;
        trk_period   = {43'd0, FALLBACK_RST} << FRAC;
        trk_seen     = 1'b0;
        trk_meas     = 1'b0;
        trk_ext      = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: first edge, first lock, smoothing,
        // too-short interval, empty and largest blocks
        push_block(1'b1, 11'd0, 1'b0);
        repeat (3) push_block(1'b0, 11'd1024, 1'b0);
        push_block(1'b1, 11'd2047, 1'b0);
        repeat (3) push_block(1'b0, 11'd2047, 1'b0);
        push_block(1'b1, 11'd0, 1'b0);
        push_block(1'b1, 11'd5, 1'b0);
        push_block(1'b0, 11'd0, 1'b0);
        push_block(1'b0, 11'd1, 1'b0);
        push_block(1'b0, 11'd1365, 1'b1);
        push_block(1'b0, 11'd682, 1'b0);
        push_block(1'b1, 11'd2047, 1'b0);
        wait_idle();

        // Short periods, fallback written while locked
        configure(300, 400, 40, 1500);
        queue_traffic(350);
        queue_clock(800, 100, 3);
        wait_idle();

        // Zero bounds: counter pinned at zero, zero intervals accepted
        configure(1, 0, 0, 0);
        queue_traffic(60);
        wait_idle();

        // Top settings: lock on a long period, a long silence held by the top
        // floor, then a lower floor lets it fall back
        configure(2097151, 8388607, 1, 2097151);
        push_block(1'b1, 11'd0, 1'b0);
        queue_clock(45000, 2047, 2);
        repeat (200) push_block(1'b0, 11'd2047, 1'b0);
        wait_idle();
        configure(2097151, 300000, 1, 2097151);
        repeat (40) push_block(1'b0, 11'd2047, 1'b0);
        push_block(1'b1, 11'd0, 1'b0);
        push_block(1'b0, 11'd2047, 1'b0);
        wait_idle();

        // Mid settings, fallback written while unlocked
        configure(5000, 20000, 500, 6000);
        queue_traffic(300);
        wait_idle();

        repeat (3) begin
            int unsigned mn;
            mn = $urandom_range(1, 2000);
            configure($urandom_range(1, 2097151), $urandom_range(0, 30000),
                      mn, mn + $urandom_range(0, 8000));
            queue_traffic(180);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("external_clock_period_tracker_tb: clean");
        end else begin
            $display("external_clock_period_tracker_tb: errors");
        end
        $finish;
    end

    // Input side: take the handshake and predict the report
    always @(posedge i_clk) begin
        s_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (s_taken)
            period_reports_due.push_back(track_block(i_s_tuser[0], i_s_tdata[10:0]));
    end

    // Input side: present the next block once its gap has run out
    always @(negedge i_clk) begin : drive_blocks
        t_audio_block nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_taken) begin
            if (s_taken)
                s_gap = draw_wait(s_calm);
            if (s_gap > 0) begin
                s_gap--;
                i_s_tvalid <= 1'b0;
            end else if (audio_blocks_pending.size() > 0
                         && !(audio_blocks_pending[0].settle
                              && period_reports_due.size() > 0)) begin
                nxt = audio_blocks_pending.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= nxt.gate;
                i_s_tdata  <= {5'd0, nxt.blk};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: compare each report word with the oldest prediction
    always @(posedge i_clk) begin : check_reports
        t_result want;
        m_taken = i_rst_n && o_m_tvalid && i_m_tready;
        if (m_taken) begin
            if (period_reports_due.size() == 0) begin
                note_error("report word with nothing expected");
            end else begin
                want = period_reports_due.pop_front();
                if (o_m_tuser[0] !== want.tick_out)
                    note_error($sformatf("tick_out %0b, expected %0b",
                                         o_m_tuser[0], want.tick_out));
                if (o_m_tuser[1] !== want.locked_external)
                    note_error($sformatf("locked_external %0b, expected %0b",
                                         o_m_tuser[1], want.locked_external));
                if (o_m_tdata[28:0] !== want.period_q8)
                    note_error($sformatf("period_q8 %0d, expected %0d",
                                         o_m_tdata[28:0], want.period_q8));
            end
        end
    end

    // Output side: random stalls between report words
    always @(negedge i_clk) begin
        if (m_taken)
            m_stall = draw_wait(m_calm);
        if (m_stall > 0) begin
            m_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: too long with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("external_clock_period_tracker_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ecpt_pkg.sv
hdl/ecpt_cfg_regs.sv
hdl/ecpt_core.sv
hdl/external_clock_period_tracker.sv
hdl/ecpt_checker.sv
verif/external_clock_period_tracker_tb.sv
